FILE: rtl/yuvrgb_pkg.sv
`default_nettype none

package yuvrgb_pkg;

    localparam int unsigned PIX_W  = 8;
    localparam int unsigned NUM_W  = 24;
    localparam int unsigned NSTG   = 5;
    localparam int unsigned NLANES = 2;

    localparam int unsigned DIV_IN_W = 22;
    localparam int unsigned RECIP_W  = 23;
    localparam int unsigned PROD_W   = DIV_IN_W + RECIP_W;
    localparam int unsigned RECIP_SH = 36;

    localparam logic signed [NUM_W-1:0] C_V_R    = 24'sd15938;
    localparam logic signed [NUM_W-1:0] C_OFFS_R = 24'sd2221300;
    localparam logic signed [NUM_W-1:0] C_U_B    = 24'sd20238;
    localparam logic signed [NUM_W-1:0] C_OFFS_B = 24'sd2771300;
    localparam logic signed [NUM_W-1:0] C_Y_RB   = 24'sd11644;
    localparam logic signed [NUM_W-1:0] C_Y_G    = 24'sd19837;
    localparam logic signed [NUM_W-1:0] C_OFFS_G = 24'sd311710;
    localparam logic signed [NUM_W-1:0] C_R_G    = 24'sd5094;
    localparam logic signed [NUM_W-1:0] C_B_G    = 24'sd1942;

    // quotient by 10000 saturates at or above this numerator
    localparam logic signed [NUM_W-1:0] C_SAT    = 24'sd2560000;
    // ceil(2^36 / 10000), exact for numerators below 2^22
    localparam logic [RECIP_W-1:0]      C_RECIP  = 23'd6871948;
    localparam logic [PIX_W-1:0]        CHAN_MAX = 8'd255;

    typedef struct packed {
        logic [NSTG-1:0] en;
    } t_lane_ctrl;

    typedef struct packed {
        logic             g_neg;
        logic             g_big;
        logic [PIX_W-1:0] g_q;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] blue;
    } t_lane_res;

    function automatic logic [PIX_W-1:0] sel_chan(input logic neg, input logic big,
                                                  input logic [PIX_W-1:0] q);
        logic [PIX_W-1:0] res;
        priority if (neg) begin
            res = '0;
        end else if (big) begin
            res = CHAN_MAX;
        end else begin
            res = q;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/yuvrgb_lane.sv
`default_nettype none

module yuvrgb_lane (
    input  wire logic                           i_clk,
    input  wire yuvrgb_pkg::t_lane_ctrl         i_ctrl,
    input  wire logic [yuvrgb_pkg::PIX_W-1:0]   i_luma,
    input  wire logic [yuvrgb_pkg::PIX_W-1:0]   i_cb,
    input  wire logic [yuvrgb_pkg::PIX_W-1:0]   i_cr,
    output yuvrgb_pkg::t_lane_res               o_res
);

    localparam int unsigned NW = yuvrgb_pkg::NUM_W;
    localparam int unsigned PW = yuvrgb_pkg::PIX_W;
    localparam int unsigned QW = yuvrgb_pkg::PROD_W;
    localparam int unsigned SH = yuvrgb_pkg::RECIP_SH;
    localparam int unsigned DW = yuvrgb_pkg::DIV_IN_W;

    logic signed [NW-1:0] y_s, u_s, v_s;
    assign y_s = $signed({(NW-PW)'(0), i_luma});
    assign u_s = $signed({(NW-PW)'(0), i_cb});
    assign v_s = $signed({(NW-PW)'(0), i_cr});

    logic signed [NW-1:0] r1_num_r, r1_num_b, r1_num_gy;
    logic signed [NW-1:0] n1_num_r, n1_num_b, n1_num_gy;

    assign n1_num_r  = yuvrgb_pkg::C_V_R * v_s + yuvrgb_pkg::C_Y_RB * y_s
                       - yuvrgb_pkg::C_OFFS_R;
    assign n1_num_b  = yuvrgb_pkg::C_U_B * u_s + yuvrgb_pkg::C_Y_RB * y_s
                       - yuvrgb_pkg::C_OFFS_B;
    assign n1_num_gy = yuvrgb_pkg::C_Y_G * y_s - yuvrgb_pkg::C_OFFS_G;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[0]) begin
            r1_num_r  <= n1_num_r;
            r1_num_b  <= n1_num_b;
            r1_num_gy <= n1_num_gy;
        end
    end

    logic [QW-1:0]        r2_prod_r, r2_prod_b, n2_prod_r, n2_prod_b;
    logic                 r2_neg_r, r2_big_r, r2_neg_b, r2_big_b;
    logic signed [NW-1:0] r2_num_gy;

    assign n2_prod_r = QW'(r1_num_r[DW-1:0]) * QW'(yuvrgb_pkg::C_RECIP);
    assign n2_prod_b = QW'(r1_num_b[DW-1:0]) * QW'(yuvrgb_pkg::C_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[1]) begin
            r2_prod_r <= n2_prod_r;
            r2_prod_b <= n2_prod_b;
            r2_neg_r  <= r1_num_r[NW-1];
            r2_neg_b  <= r1_num_b[NW-1];
            r2_big_r  <= (r1_num_r >= yuvrgb_pkg::C_SAT);
            r2_big_b  <= (r1_num_b >= yuvrgb_pkg::C_SAT);
            r2_num_gy <= r1_num_gy;
        end
    end

    logic [PW-1:0]        r3_red, r3_blue;
    logic signed [NW-1:0] r3_num_gy;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[2]) begin
            r3_red    <= yuvrgb_pkg::sel_chan(r2_neg_r, r2_big_r, r2_prod_r[SH+PW-1:SH]);
            r3_blue   <= yuvrgb_pkg::sel_chan(r2_neg_b, r2_big_b, r2_prod_b[SH+PW-1:SH]);
            r3_num_gy <= r2_num_gy;
        end
    end

    logic signed [NW-1:0] r4_num_g, n4_num_g, r_s, b_s;
    logic [PW-1:0]        r4_red, r4_blue;

    assign r_s      = $signed({(NW-PW)'(0), r3_red});
    assign b_s      = $signed({(NW-PW)'(0), r3_blue});
    assign n4_num_g = r3_num_gy - yuvrgb_pkg::C_R_G * r_s - yuvrgb_pkg::C_B_G * b_s;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[3]) begin
            r4_num_g <= n4_num_g;
            r4_red   <= r3_red;
            r4_blue  <= r3_blue;
        end
    end

    logic [QW-1:0] r5_prod_g, n5_prod_g;
    logic          r5_neg_g, r5_big_g;
    logic [PW-1:0] r5_red, r5_blue;

    assign n5_prod_g = QW'(r4_num_g[DW-1:0]) * QW'(yuvrgb_pkg::C_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[4]) begin
            r5_prod_g <= n5_prod_g;
            r5_neg_g  <= r4_num_g[NW-1];
            r5_big_g  <= (r4_num_g >= yuvrgb_pkg::C_SAT);
            r5_red    <= r4_red;
            r5_blue   <= r4_blue;
        end
    end

    assign o_res.g_neg = r5_neg_g;
    assign o_res.g_big = r5_big_g;
    assign o_res.g_q   = r5_prod_g[SH+PW-1:SH];
    assign o_res.red   = r5_red;
    assign o_res.blue  = r5_blue;

endmodule

`default_nettype wire

FILE: rtl/yuvrgb_merge.sv
`default_nettype none

module yuvrgb_merge (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire logic                                        i_valid,
    input  wire yuvrgb_pkg::t_lane_res [yuvrgb_pkg::NLANES-1:0] i_res,
    output logic                                             o_ready,
    output logic                                             o_m_tvalid,
    input  wire logic                                        i_m_tready,
    output logic [3*yuvrgb_pkg::PIX_W*yuvrgb_pkg::NLANES-1:0] o_m_tdata
);

    localparam int unsigned PW = yuvrgb_pkg::PIX_W;
    localparam int unsigned DW = 3 * PW * yuvrgb_pkg::NLANES;

    logic          r_valid;
    logic [DW-1:0] r_data, n_data;

    always_comb begin
        n_data = '0;
        for (int i = 0; i < int'(yuvrgb_pkg::NLANES); i++) begin
            n_data[(3*i)*PW +: PW]   = i_res[i].red;
            n_data[(3*i+1)*PW +: PW] = yuvrgb_pkg::sel_chan(i_res[i].g_neg, i_res[i].g_big,
                                                            i_res[i].g_q);
            n_data[(3*i+2)*PW +: PW] = i_res[i].blue;
        end
    end

    assign o_ready = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;

endmodule

`default_nettype wire

FILE: rtl/yuv420_pixel_pair_to_rgb_unit.sv
// Path: an accepted input word passes through five lane stages, then the output register.
// Throughput: one pixel pair per cycle; five lane stages and the output register
//   each take a new word whenever they are empty or their contents move on.
// Reset: synchronous, active low; clears all valid bits, datapath is not reset.
`default_nettype none

module yuv420_pixel_pair_to_rgb_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // luma_first, luma_second, chroma_blue, chroma_red
    input  wire logic [31:0] i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // red_first, green_first, blue_first, red_second, green_second, blue_second
    output logic [47:0]      o_m_axis_tdata
);

    localparam int unsigned NS = yuvrgb_pkg::NSTG;
    localparam int unsigned PW = yuvrgb_pkg::PIX_W;

    logic [NS-1:0]          r_vld, n_vld;
    logic [NS:0]            en;
    logic                   merge_ready;
    yuvrgb_pkg::t_lane_ctrl ctrl;
    yuvrgb_pkg::t_lane_res [yuvrgb_pkg::NLANES-1:0] res;

    always_comb begin
        en[NS] = merge_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        for (int k = 0; k < int'(NS); k++) begin
            if (en[k]) begin
                n_vld[k] = (k == 0) ? i_s_axis_tvalid : r_vld[(k == 0) ? 0 : k - 1];
            end else begin
                n_vld[k] = r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign ctrl.en         = en[NS-1:0];
    assign o_s_axis_tready = en[0];

    yuvrgb_lane u_lane0 (
        .i_clk  (i_clk),
        .i_ctrl (ctrl),
        .i_luma (i_s_axis_tdata[PW-1:0]),
        .i_cb   (i_s_axis_tdata[3*PW-1:2*PW]),
        .i_cr   (i_s_axis_tdata[4*PW-1:3*PW]),
        .o_res  (res[0])
    );

    yuvrgb_lane u_lane1 (
        .i_clk  (i_clk),
        .i_ctrl (ctrl),
        .i_luma (i_s_axis_tdata[2*PW-1:PW]),
        .i_cb   (i_s_axis_tdata[3*PW-1:2*PW]),
        .i_cr   (i_s_axis_tdata[4*PW-1:3*PW]),
        .o_res  (res[1])
    );

    yuvrgb_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_vld[NS-1]),
        .i_res      (res),
        .o_ready    (merge_ready),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata)
    );

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld[0])
        else $error("accepted word did not enter first stage");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready && (&r_vld)))
        else $error("input stalled while pipeline had room");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && o_m_axis_tvalid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input accepted into full stalled pipeline");

endmodule

`default_nettype wire
